### rtl/rfdc_pkg.sv
// Package for the receive deframer: line codes, CRC helpers and the result record.
package rfdc_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7e;
  localparam logic [7:0]  ESC_BYTE  = 8'h7d;
  localparam logic [7:0]  ESC_FLAG  = 8'h9e;
  localparam logic [7:0]  ESC_ESC   = 8'h9d;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'h0000;
  localparam logic [8:0]  LEN_INDEX = 9'd6;
  localparam logic [8:0]  CRC_LO_OFS = 9'd7;
  localparam logic [8:0]  CRC_HI_OFS = 9'd8;

  // One decoded byte headed for the output register
  typedef struct packed {
    logic       emit;
    logic [7:0] frame_byte;
    logic [8:0] byte_index;
    logic       frame_end;
    logic       crc_ok;
  } result_t;

  // Table entry for the byte-wise CRC-16 (poly 0x1021), eight shift steps
  function automatic logic [15:0] crc_table_entry(input logic [7:0] hi);
    logic [15:0] v;
    v = {hi, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

  // crc = T[crc >> 8] ^ (crc << 8) ^ byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
    return crc_table_entry(crc[15:8]) ^ {crc[7:0], 8'h00} ^ {8'h00, d};
  endfunction

endpackage

### rtl/rfdc_if.sv
// Stream interfaces for raw line bytes and decoded frame bytes.
interface rfdc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfdc_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [8:0] byte_index;
  logic       frame_end;
  logic       crc_ok;

  modport source (output valid, output frame_byte, output byte_index, output frame_end,
                  output crc_ok, input ready);
  modport sink   (input valid, input frame_byte, input byte_index, input frame_end,
                  input crc_ok, output ready);
endinterface

### rtl/rfdc_decode.sv
// Frame state, escape removal, length capture and CRC update for one byte.
module rfdc_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        raw,
  output rfdc_pkg::result_t res
);
  import rfdc_pkg::*;

  logic        in_frame, in_frame_next;
  logic        esc, esc_next;
  logic [8:0]  count, count_next;
  logic [7:0]  len, len_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  crc_lo, crc_lo_next;
  logic        have;
  logic [7:0]  d;
  logic [7:0]  len_eff;
  logic [8:0]  len_ext;

  // Next-state and result for the byte being processed
  always_comb begin
    in_frame_next = in_frame;
    esc_next      = esc;
    count_next    = count;
    len_next      = len;
    crc_next      = crc;
    crc_lo_next   = crc_lo;
    have          = 1'b0;
    d             = raw;
    len_eff       = len;
    len_ext       = {1'b0, len};
    res           = '0;
    if (fire) begin
      if (raw == FLAG_BYTE) begin
        in_frame_next  = 1'b1;
        esc_next       = 1'b0;
        count_next     = 9'd1;
        len_next       = 8'h00;
        crc_next       = CRC_INIT;
        crc_lo_next    = 8'h00;
        res.emit       = 1'b1;
        res.frame_byte = FLAG_BYTE;
      end else if (in_frame) begin
        if (esc) begin
          // a second escape keeps the mark set
          if (raw != ESC_BYTE) begin
            esc_next = 1'b0;
            have     = 1'b1;
            if (raw == ESC_FLAG) begin
              d = FLAG_BYTE;
            end else if (raw == ESC_ESC) begin
              d = ESC_BYTE;
            end
          end
        end else if (raw == ESC_BYTE) begin
          esc_next = 1'b1;
        end else begin
          have = 1'b1;
        end

        if (have) begin
          len_eff  = (count == LEN_INDEX) ? d : len;
          len_ext  = {1'b0, len_eff};
          len_next = len_eff;
          if (count != 9'd0 && count <= len_ext + LEN_INDEX) begin
            crc_next = crc_step(crc, d);
          end
          if (count >= CRC_LO_OFS && count == len_ext + CRC_LO_OFS) begin
            crc_lo_next = d;
          end
          if (count >= CRC_HI_OFS && count == len_ext + CRC_HI_OFS) begin
            res.frame_end = 1'b1;
            res.crc_ok    = (crc_lo == crc[7:0]) && (d == crc[15:8]);
            in_frame_next = 1'b0;
            esc_next      = 1'b0;
          end
          count_next     = count + 9'd1;
          res.emit       = 1'b1;
          res.frame_byte = d;
          res.byte_index = count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      esc      <= 1'b0;
      count    <= 9'd0;
      len      <= 8'h00;
      crc      <= CRC_INIT;
      crc_lo   <= 8'h00;
    end else begin
      in_frame <= in_frame_next;
      esc      <= esc_next;
      count    <= count_next;
      len      <= len_next;
      crc      <= crc_next;
      crc_lo   <= crc_lo_next;
    end
  end
endmodule

### rtl/rfdc_out_reg.sv
// Result register driving the decoded-byte stream.
module rfdc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  rfdc_pkg::result_t res,
  output logic              space,
  rfdc_frame_if.source      frame
);
  import rfdc_pkg::*;

  logic    valid;
  result_t data;

  // Room for a new result when empty or being drained this cycle
  assign space = !valid || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (frame.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign frame.valid      = valid;
  assign frame.frame_byte = data.frame_byte;
  assign frame.byte_index = data.byte_index;
  assign frame.frame_end  = data.frame_end;
  assign frame.crc_ok     = data.crc_ok;
endmodule

### rtl/rx_frame_destuff_crc_check.sv
// Top level: input register, byte decoder and result register of the deframer.
//
//   channel  dir  payload                                        handshake
//   rx       in   rx_byte[7:0]                                   valid/ready
//   frame    out  frame_byte[7:0] byte_index[8:0] frame_end crc_ok  valid/ready
//
// One raw byte per cycle sustained while the output accepts; each byte is first captured in the
// input register, then decoded into the result register.
// The decode step (escape removal plus one table CRC step) sets the cycle.
// Synchronous reset clears frame state; the block then waits for a flag.
// A stalled output holds the input register; escapes and dropped bytes give no result.
module rx_frame_destuff_crc_check (
  input  logic        clk,
  input  logic        rst,
  rfdc_byte_if.sink   rx,
  rfdc_frame_if.source frame
);
  import rfdc_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       space;
  logic       advance;
  result_t    res;

  // Input stage moves on whenever the result register can take a value
  assign advance  = in_valid && space;
  assign rx.ready = !in_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  rfdc_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .raw  (in_byte),
    .res  (res)
  );

  rfdc_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (res.emit),
    .res   (res),
    .space (space),
    .frame (frame)
  );
endmodule
